>>> design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OPCODE_W   = 4;
   localparam int unsigned LEN_W      = 64;
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned HBC_W      = 3;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [OPCODE_W-1:0] OP_DATA_LAST = 4'h3;
   localparam logic [OPCODE_W-1:0] OP_CTRL_FIRST = 4'h8;
   localparam logic [OPCODE_W-1:0] OP_CTRL_LAST = 4'hB;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   localparam logic [HBC_W-1:0] EXT16_BYTES = 3'd2;
   localparam logic [HBC_W-1:0] EXT64_BYTES = 3'(8);
   localparam logic [HBC_W-1:0] MASK_BYTES  = 3'd4;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_MASK,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                has_byte;
      logic [OPCODE_W-1:0] opcode;
      logic                fin;
      logic                frame_end;
      logic                bad_opcode;
   } rsp_item_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
      logic              buffer_end;
   } req_item_type;

endpackage

>>> design/wsd_in_stage.sv
// Input register for the deframer request channel.
// Depends on wsd_pkg.
module wsd_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wsd_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   input  logic                            req_tlast,   // buffer_end
   input  logic                            advance,
   output wsd_pkg::req_item_type           item
);
   import wsd_pkg::*;

   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;

   assign req_tready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata[BYTE_W-1:0];
         last_ff <= req_tlast;
      end
   end

   assign item.valid      = valid_ff;
   assign item.rx_byte    = byte_ff;
   assign item.buffer_end = last_ff;

endmodule

>>> design/wsd_parser.sv
// Frame header parser and payload unmasking; holds all frame state.
// Depends on wsd_pkg.
module wsd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  wsd_pkg::req_item_type item,
   input  logic                  advance,
   output logic                  emit,
   output wsd_pkg::rsp_item_type result
);
   import wsd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  fin_ff, fin_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic                  mask_ff, mask_in;
   logic [HBC_W-1:0]      hbc_ff, hbc_in, hbc_nx, hbc_inc;
   logic [LEN_W-1:0]      rem_ff, rem_in, rem_nx;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [1:0]            idx_ff, idx_in, idx_nx;
   logic                  disc_ff, disc_in;

   logic                  fire;
   logic [BYTE_W-1:0]     b;
   logic                  bad_hit, len_done, hdr_done, pay_hit, rem_zero;
   logic [BYTE_W-1:0]     key_byte;

   assign fire    = item.valid && advance;
   assign b       = item.rx_byte;
   assign hbc_inc = hbc_ff + 3'd1;

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // datapath: field updates and event flags
   always_comb begin
      fin_in   = fin_ff;
      op_in    = op_ff;
      mask_in  = mask_ff;
      hbc_nx   = hbc_ff;
      rem_nx   = rem_ff;
      key_in   = key_ff;
      idx_nx   = idx_ff;
      disc_in  = disc_ff;
      bad_hit  = 1'b0;
      len_done = 1'b0;
      hdr_done = 1'b0;
      pay_hit  = 1'b0;
      if (!disc_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in = b[7];
               op_in  = b[OPCODE_W-1:0];
               if ((op_in > OP_DATA_LAST && op_in < OP_CTRL_FIRST) || op_in > OP_CTRL_LAST) begin
                  bad_hit = 1'b1;
                  disc_in = 1'b1;
               end
            end
            PH_HDR1: begin
               mask_in = b[7];
               hbc_nx  = '0;
               rem_nx  = '0;
               if (b[6:0] != LEN_CODE_EXT16 && b[6:0] != LEN_CODE_EXT64) begin
                  rem_nx   = LEN_W'(b[6:0]);
                  len_done = 1'b1;
               end
            end
            PH_EXT16, PH_EXT64: begin
               rem_nx = {rem_ff[LEN_W-BYTE_W-1:0], b};
               hbc_nx = hbc_inc;
               if (hbc_inc == ((phase_ff == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                  len_done = 1'b1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[KEY_W-BYTE_W-1:0], b};
               hbc_nx = hbc_inc;
               if (hbc_inc == MASK_BYTES) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               pay_hit = 1'b1;
               idx_nx  = idx_ff + 2'd1;
               rem_nx  = rem_ff - LEN_W'(1);
            end
            default: begin
            end
         endcase
         if (len_done) begin
            hbc_nx = '0;
            if (mask_in) begin
               key_in = '0;
            end else begin
               hdr_done = 1'b1;
            end
         end
         if (hdr_done) begin
            idx_nx = '0;
            hbc_nx = '0;
         end
      end
      rem_zero = (rem_nx == '0);
      hbc_in   = item.buffer_end ? '0 : hbc_nx;
      rem_in   = item.buffer_end ? '0 : rem_nx;
      idx_in   = item.buffer_end ? '0 : idx_nx;
      if (item.buffer_end) begin
         disc_in = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!disc_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               if (!bad_hit) begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (b[6:0] == LEN_CODE_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (b[6:0] == LEN_CODE_EXT64) begin
                  phase_in = PH_EXT64;
               end
            end
            PH_EXT16, PH_EXT64, PH_MASK: begin
            end
            PH_PAYLOAD: begin
               if (rem_zero) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
         if (len_done && mask_in) begin
            phase_in = PH_MASK;
         end
         if (hdr_done) begin
            phase_in = rem_zero ? PH_HDR0 : PH_PAYLOAD;
         end
      end
      if (item.buffer_end) begin
         phase_in = PH_HDR0;
      end
   end

   // result
   always_comb begin
      emit                = fire && (bad_hit || pay_hit || (hdr_done && rem_zero));
      result.payload_byte = '0;
      result.has_byte     = pay_hit;
      result.opcode       = op_in;
      result.fin          = fin_in;
      result.frame_end    = (pay_hit || hdr_done) && rem_zero;
      result.bad_opcode   = bad_hit;
      if (pay_hit) begin
         result.payload_byte = mask_ff ? (b ^ key_byte) : b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         fin_ff   <= 1'b0;
         op_ff    <= '0;
         mask_ff  <= 1'b0;
         hbc_ff   <= '0;
         rem_ff   <= '0;
         key_ff   <= '0;
         idx_ff   <= '0;
         disc_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         op_ff    <= op_in;
         mask_ff  <= mask_in;
         hbc_ff   <= hbc_in;
         rem_ff   <= rem_in;
         key_ff   <= key_in;
         idx_ff   <= idx_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

>>> design/wsd_out_stage.sv
// Result register for the deframer response channel.
// Depends on wsd_pkg.
module wsd_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            emit,
   input  wsd_pkg::rsp_item_type           result,
   output logic                            advance,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [7:0] payload_byte, [8] has_byte,
                                                       // [12:9] opcode, [13] fin, [15:14] zero
   output logic                            rsp_tlast,  // frame_end
   output logic                            rsp_tuser   // bad_opcode
);
   import wsd_pkg::*;

   logic         valid_ff;
   rsp_item_type item_ff;

   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, item_ff.fin, item_ff.opcode, item_ff.has_byte,
                        item_ff.payload_byte};
   assign rsp_tlast  = item_ff.frame_end;
   assign rsp_tuser  = item_ff.bad_opcode;

endmodule

>>> design/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser, wsd_out_stage.
//
// channel   direction  tdata                       tlast        tuser
// req_      in         [7:0] rx_byte               buffer_end   -
// rsp_      out        [7:0] payload_byte,[8] has,  frame_end    bad_opcode
//                      [12:9] opcode,[13] fin
//
// One byte per cycle sustained while rsp_tready is not stalled; a request is registered in the
// input register and its result in the result register.
// The parser state advances only when the result register can take a new entry.
// Synchronous reset returns the parser to the first header byte.
// A stalled rsp_tready holds the result and backs pressure up to req_tready.
module websocket_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wsd_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   input  logic                            req_tlast,   // buffer_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] payload_byte, [8] has_byte,
                                                        // [12:9] opcode, [13] fin, [15:14] zero
   output logic                            rsp_tlast,   // frame_end
   output logic                            rsp_tuser    // bad_opcode
);
   import wsd_pkg::*;

   req_item_type item;
   rsp_item_type result;
   logic         advance;
   logic         emit;

   wsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item       (item)
   );

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .emit    (emit),
      .result  (result)
   );

   wsd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> design/wsd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer.
module wsd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);
   import wsd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_bad_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && !rsp_tdata[8])
      else $error("bad opcode response carries data or frame end");

   a_bad_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[11])
      else $error("bad opcode flagged on a defined opcode");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'h00)
      else $error("response without data carries a nonzero byte");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
